FILE: hw/rtl/kar_pkg.sv
// shared types and constants for the keypad auto-repeat block
package kar_pkg;

  localparam int unsigned KeyW    = 12;
  localparam int unsigned MaskW   = 13;
  localparam int unsigned KeyBitW = 4;
  localparam int unsigned TickW   = 8;
  localparam int unsigned DelayW  = 7;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [DelayW-1:0] FirstDelayRst = 7'd18;
  localparam logic [DelayW-1:0] NextDelayRst  = 7'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REMAP = 2'd0,
    CFG_FIRST = 2'd1,
    CFG_NEXT  = 2'd2
  } kar_cfg_e;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_POLL = 1'b1
  } kar_req_e;

  typedef enum logic [1:0] {
    ALU_ADD_FIRST,
    ALU_ADD_NEXT,
    ALU_SUB_TICK
  } kar_alu_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_ARM,
    ST_DONE
  } kar_state_e;

  typedef struct packed {
    kar_req_e          req_type;
    logic [KeyW-1:0]   scan_keys;
  } kar_in_t;

  typedef struct packed {
    logic [KeyW-1:0]   pressed_mask;
    logic [KeyW-1:0]   held_mask;
    logic [MaskW-1:0]  keys_seen;
  } kar_out_t;

  typedef struct packed {
    logic [TickW-1:0]  tick_count;
    logic [MaskW-1:0]  pending;
    logic [MaskW-1:0]  repressed;
    logic [MaskW-1:0]  released;
  } kar_acc_t;

  typedef struct packed {
    logic busy;
    logic done;
  } kar_walk_sts_t;

endpackage

FILE: hw/rtl/kar_alu.sv
// shared 8-bit adder for deadline arming and deadline-minus-tick compare
module kar_alu (
  input  kar_pkg::kar_alu_e               op_i,
  input  logic [kar_pkg::TickW-1:0]       tick_i,
  input  logic [kar_pkg::TickW-1:0]       deadline_i,
  input  logic [kar_pkg::DelayW-1:0]      first_i,
  input  logic [kar_pkg::DelayW-1:0]      next_i,
  output logic [kar_pkg::TickW-1:0]       sum_o
);
  import kar_pkg::*;

  logic [TickW-1:0] opa;
  logic [TickW-1:0] opb;
  logic [TickW-1:0] cin;

  always_comb begin
    opa = tick_i;
    opb = {1'b0, first_i};
    cin = '0;
    unique case (op_i)
      ALU_ADD_FIRST: opb = {1'b0, first_i};
      ALU_ADD_NEXT:  opb = {1'b0, next_i};
      ALU_SUB_TICK: begin
        // deadline - tick as deadline + ~tick + 1
        opa = deadline_i;
        opb = ~tick_i;
        cin = TickW'(1);
      end
      default: opb = {1'b0, first_i};
    endcase
  end

  assign sum_o = opa + opb + cin;

endmodule

FILE: hw/rtl/kar_accum.sv
// frame tick counter and accumulated seen, re-pressed and released masks
module kar_accum (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       tick_en_i,
  input  logic [kar_pkg::KeyW-1:0]   scan_i,
  input  logic                       remap_en_i,
  input  logic [kar_pkg::KeyW-1:0]   held_i,
  input  logic                       clear_i,
  output kar_pkg::kar_acc_t          acc_o
);
  import kar_pkg::*;

  kar_acc_t          acc_q, acc_d;
  logic [MaskW-1:0]  keys;

  function automatic logic [MaskW-1:0] remap(input logic [KeyW-1:0] k);
    logic [MaskW-1:0] r;
    r     = '0;
    r[3]  = k[11];
    r[2]  = k[10];
    r[12] = k[8];
    r[5]  = k[7];
    r[1]  = k[6];
    r[8]  = k[4];
    r[4]  = k[3];
    r[6]  = k[2];
    r[7]  = k[0];
    return r;
  endfunction

  always_comb begin
    keys = remap_en_i ? remap(scan_i) : {1'b0, scan_i};
  end

  always_comb begin
    acc_d = acc_q;
    if (tick_en_i) begin
      acc_d.tick_count = acc_q.tick_count + TickW'(1);
      acc_d.pending    = acc_q.pending | keys;
      acc_d.repressed  = acc_q.repressed | (keys & acc_q.released);
      acc_d.released   = acc_q.released | ({1'b0, held_i} & ~keys);
    end else if (clear_i) begin
      acc_d.pending   = '0;
      acc_d.repressed = '0;
      acc_d.released  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: hw/rtl/kar_walk.sv
// poll sequencer: walks the keys one a cycle, owns held bits and repeat deadlines
module kar_walk #(
  parameter int unsigned NUM_KEYS = 11
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  kar_pkg::kar_acc_t          acc_i,
  input  logic [kar_pkg::DelayW-1:0] first_i,
  input  logic [kar_pkg::DelayW-1:0] next_i,
  output logic [kar_pkg::KeyW-1:0]   held_o,
  output kar_pkg::kar_walk_sts_t     sts_o,
  output kar_pkg::kar_out_t          res_o
);
  import kar_pkg::*;

  localparam int unsigned IdxW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  kar_state_e          state_q, state_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [KeyW-1:0]     held_q, held_d;
  logic [KeyW-1:0]     pressed_q, pressed_d;
  logic [TickW-1:0]    dl_q [NUM_KEYS];

  logic [KeyBitW-1:0]  kb;
  logic                last;
  logic                seen_b, rep_b, rel_b, held_b;
  logic                expired;
  logic                dl_we;
  kar_alu_e            alu_op;
  logic [TickW-1:0]    alu_sum;
  logic [MaskW-1:0]    h13, p13;

  function automatic logic h13_cur(input logic [KeyW-1:0] h, input logic [KeyBitW-1:0] b);
    logic [MaskW-1:0] w;
    w = {1'b0, h};
    return w[b];
  endfunction

  // key i lives at mask bit i+1
  assign kb      = KeyBitW'(idx_q) + KeyBitW'(1);
  assign last    = (idx_q == IdxW'(NUM_KEYS - 1));
  assign seen_b  = acc_i.pending[kb];
  assign rep_b   = acc_i.repressed[kb];
  assign rel_b   = acc_i.released[kb];
  assign held_b  = h13_cur(held_q, kb);
  assign expired = alu_sum[TickW-1];

  kar_alu u_alu (
    .op_i       (alu_op),
    .tick_i     (acc_i.tick_count),
    .deadline_i (dl_q[idx_q]),
    .first_i    (first_i),
    .next_i     (next_i),
    .sum_o      (alu_sum)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_WALK;
      ST_WALK: begin
        if (!seen_b) begin
          state_d = last ? ST_DONE : ST_WALK;
        end else if (rep_b) begin
          state_d = ST_DONE;
        end else if (held_b) begin
          if (!expired) state_d = last ? ST_DONE : ST_WALK;
          else          state_d = rel_b ? ST_DONE : ST_ARM;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_ARM:  state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    idx_d  = idx_q;
    dl_we  = 1'b0;
    alu_op = ALU_SUB_TICK;
    h13    = {1'b0, held_q};
    p13    = {1'b0, pressed_q};
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          idx_d = '0;
          p13   = '0;
        end
      end
      ST_WALK: begin
        if (!seen_b) begin
          h13[kb] = 1'b0;
          if (!last) idx_d = idx_q + IdxW'(1);
        end else if (rep_b) begin
          alu_op  = ALU_ADD_FIRST;
          dl_we   = 1'b1;
          p13[kb] = 1'b1;
          h13[kb] = 1'b1;
        end else if (held_b) begin
          alu_op = ALU_SUB_TICK;
          if (rel_b) h13[kb] = 1'b0;
          if (!expired && !last) idx_d = idx_q + IdxW'(1);
        end else if (!rel_b) begin
          alu_op  = ALU_ADD_FIRST;
          dl_we   = 1'b1;
          p13[kb] = 1'b1;
          h13[kb] = 1'b1;
        end
      end
      ST_ARM: begin
        alu_op  = ALU_ADD_NEXT;
        dl_we   = 1'b1;
        p13[kb] = 1'b1;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
    // mask bit 12 has no place in the 12-bit masks
    held_d    = h13[KeyW-1:0];
    pressed_d = p13[KeyW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      held_q    <= '0;
      pressed_q <= '0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      held_q    <= held_d;
      pressed_q <= pressed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dl_we) begin
      dl_q[idx_q] <= alu_sum;
    end
  end

  assign held_o     = held_q;
  assign sts_o.busy = (state_q != ST_IDLE);
  assign sts_o.done = (state_q == ST_DONE);

  always_comb begin
    res_o.pressed_mask = pressed_q;
    res_o.held_mask    = held_q;
    res_o.keys_seen    = acc_i.pending;
  end

endmodule

FILE: hw/rtl/keypad_autorepeat.sv
// keypad auto-repeat top level: config registers, input handshake, result register
// tick beat: state updated at the accepting edge; no result
// poll beat: keys walked in order (up to NUM_KEYS), then an arm step when a repeat is armed,
//   then a wrap-up step; the result register loads from the wrap-up step
// the key walk is set by the single shared deadline adder, one key per cycle
// input stalls while a poll is walking or a result waits; reset clears counts, masks, held bits
module keypad_autorepeat #(
  parameter int unsigned NUM_KEYS = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kar_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [kar_pkg::DelayW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  kar_pkg::kar_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output kar_pkg::kar_out_t             out_data_o
);
  import kar_pkg::*;

  logic               remap_q;
  logic [DelayW-1:0]  first_q;
  logic [DelayW-1:0]  next_q;
  logic               out_valid_q;
  kar_out_t           out_data_q;

  logic               in_acc;
  logic               tick_en;
  logic               start;
  kar_acc_t           acc;
  logic [KeyW-1:0]    held;
  kar_walk_sts_t      sts;
  kar_out_t           res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remap_q <= 1'b0;
      first_q <= FirstDelayRst;
      next_q  <= NextDelayRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REMAP: remap_q <= cfg_data_i[0];
        CFG_FIRST: first_q <= cfg_data_i;
        CFG_NEXT:  next_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = sts.busy | out_valid_q;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign tick_en    = in_acc & (in_data_i.req_type == REQ_TICK);
  assign start      = in_acc & (in_data_i.req_type == REQ_POLL);

  kar_accum u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_en_i  (tick_en),
    .scan_i     (in_data_i.scan_keys),
    .remap_en_i (remap_q),
    .held_i     (held),
    .clear_i    (sts.done),
    .acc_o      (acc)
  );

  kar_walk #(
    .NUM_KEYS (NUM_KEYS)
  ) u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .acc_i   (acc),
    .first_i (first_q),
    .next_i  (next_q),
    .held_o  (held),
    .sts_o   (sts),
    .res_o   (res)
  );

  // result beat register; a poll never finishes while a result still waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sts.done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sts.done) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
